// ===== hdl/mctp_pkg.sv =====
package mctp_pkg;

  localparam int NUM_PINS_DEFAULT = 14;

  localparam int PIN_W      = 4;
  localparam int DUTY_W     = 16;
  localparam int TPP_W      = 8;
  localparam int TC_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // doubled duty is one bit wider than the duty field
  localparam int DIVIDEND_W = DUTY_W + 1;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [TPP_W-1:0] TPP_RESET     = TPP_W'(100);
  localparam logic [TC_W-1:0]  TC_RESET      = TC_W'(200);
  localparam logic [TPP_W-1:0] TURN_ON_RESET = TPP_W'(255);

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TICK_COUNTS      = CFG_IDX_W'(1);

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_DUTY = 1'b1;

  typedef struct packed {
    logic capture;
    logic div_step;
    logic tick_commit;
    logic duty_commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_action;
    logic slot_free;
  } dp_status_t;

endpackage

// ===== hdl/mctp_ifs.sv =====
interface mctp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [mctp_pkg::PIN_W-1:0]  pin;
  logic [mctp_pkg::DUTY_W-1:0] duty_us;

  modport source (output valid, action, pin, duty_us, input ready);
  modport sink (input valid, action, pin, duty_us, output ready);
endinterface

interface mctp_out_if #(
  parameter int NUM_PINS = mctp_pkg::NUM_PINS_DEFAULT
);
  logic                valid;
  logic                ready;
  logic [NUM_PINS-1:0] pin_levels;
  logic                period_end;

  modport source (output valid, pin_levels, period_end, input ready);
  modport sink (input valid, pin_levels, period_end, output ready);
endinterface

interface mctp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mctp_pkg::CFG_IDX_W-1:0]  index;
  logic [mctp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/mctp_ctrl.sv =====
module mctp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mctp_pkg::dp_status_t status,
  output mctp_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DIV,
    S_DUTY
  } state_t;

  state_t                           state;
  logic [mctp_pkg::DIV_CNT_W-1:0]   step_cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.capture     = (state == S_IDLE) && in_valid;
    cmd.div_step    = (state == S_DIV);
    cmd.tick_commit = (state == S_TICK) && status.slot_free;
    cmd.duty_commit = (state == S_DUTY) && status.slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          step_cnt <= '0;
          if (in_valid) begin
            state <= (status.in_action == mctp_pkg::ACT_DUTY) ? S_DIV : S_TICK;
          end
        end
        S_TICK: begin
          if (status.slot_free) begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == mctp_pkg::DIV_CNT_W'(mctp_pkg::DIV_STEPS - 1)) begin
            state <= S_DUTY;
          end
        end
        S_DUTY: begin
          if (status.slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/mctp_datapath.sv =====
module mctp_datapath #(
  parameter int NUM_PINS = mctp_pkg::NUM_PINS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  mctp_in_if.sink              item_in,
  mctp_out_if.source           result_out,
  mctp_cfg_if.sink             cfg,
  input  mctp_pkg::ctrl_cmd_t  cmd,
  output mctp_pkg::dp_status_t status
);

  localparam int DW = mctp_pkg::DIVIDEND_W;
  localparam int TW = mctp_pkg::TPP_W;

  // configuration
  logic [TW-1:0]              ticks_per_period;
  logic [mctp_pkg::TC_W-1:0]  tick_counts;

  // pwm state
  logic [TW-1:0]       period_counter;
  logic [TW-1:0]       turn_on_tick [NUM_PINS];
  logic [NUM_PINS-1:0] output_levels;

  // captured word and divider
  logic [mctp_pkg::PIN_W-1:0] pin_q;
  logic [DW-1:0]              dividend;
  logic [DW-1:0]              quotient;
  logic [mctp_pkg::TC_W-1:0]  remainder;

  // result register
  logic                out_valid;
  logic [NUM_PINS-1:0] out_levels;
  logic                out_end;

  logic [mctp_pkg::TC_W-1:0] divisor;
  logic [DW-1:0]             rem_shift;
  logic                      rem_ge;
  logic [TW-1:0]             on_tick;
  logic [TW-1:0]             cnt_inc;
  logic [NUM_PINS-1:0]       match;
  logic [NUM_PINS-1:0]       raised;
  logic                      wrap;

  assign cfg.ready = 1'b1;

  assign status.in_action = item_in.action;
  assign status.slot_free = !out_valid || result_out.ready;

  assign result_out.valid      = out_valid;
  assign result_out.pin_levels = out_levels;
  assign result_out.period_end = out_end;

  // zero count per tick acts as one
  assign divisor = (tick_counts == '0) ? mctp_pkg::TC_W'(1) : tick_counts;

  assign rem_shift = {remainder, dividend[DW-1]};
  assign rem_ge    = (rem_shift >= DW'(divisor));

  assign on_tick = (quotient >= DW'(ticks_per_period)) ? '0
                 : ticks_per_period - quotient[TW-1:0];

  assign cnt_inc = period_counter + 1'b1;
  assign wrap    = (cnt_inc >= ticks_per_period);

  always_comb begin
    for (int i = 0; i < NUM_PINS; i++) begin
      match[i] = (turn_on_tick[i] == cnt_inc);
    end
    raised = output_levels | match;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_period <= mctp_pkg::TPP_RESET;
      tick_counts      <= mctp_pkg::TC_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mctp_pkg::REG_TICKS_PER_PERIOD: ticks_per_period <= cfg.data[TW-1:0];
        mctp_pkg::REG_TICK_COUNTS:      tick_counts      <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pin_q     <= item_in.pin;
      dividend  <= {item_in.duty_us, 1'b0};
      quotient  <= '0;
      remainder <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[DW-2:0], 1'b0};
      quotient <= {quotient[DW-2:0], rem_ge};
      if (rem_ge) begin
        remainder <= mctp_pkg::TC_W'(rem_shift - DW'(divisor));
      end else begin
        remainder <= rem_shift[mctp_pkg::TC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_counter <= '0;
      output_levels  <= '0;
      for (int i = 0; i < NUM_PINS; i++) begin
        turn_on_tick[i] <= mctp_pkg::TURN_ON_RESET;
      end
    end else if (cmd.tick_commit) begin
      if (wrap) begin
        period_counter <= '0;
        output_levels  <= '0;
      end else begin
        period_counter <= cnt_inc;
        output_levels  <= raised;
      end
    end else if (cmd.duty_commit) begin
      for (int i = 0; i < NUM_PINS; i++) begin
        if (int'(pin_q) == i) begin
          turn_on_tick[i] <= on_tick;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.tick_commit || cmd.duty_commit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_commit) begin
      out_levels <= wrap ? '0 : raised;
      out_end    <= wrap;
    end else if (cmd.duty_commit) begin
      out_levels <= output_levels;
      out_end    <= 1'b0;
    end
  end

endmodule

// ===== hdl/multi_channel_tick_pwm_core.sv =====
// multi-channel tick pwm core
// item_in carries one word per event: action tick advances the period counter,
// action set-duty stores the turn-on tick of one pin from a duty in microseconds
// result_out returns exactly one word per input word: the level of every pin
// after that word, and period_end when a tick closed the period
// cfg writes ticks_per_period (index 0) and tick_counts (index 1); cfg.ready is
// always high; the user must write only while no word is in flight (unchecked)
// a tick word passes S_TICK and then the result register; a set-duty word passes
// the 17-step bit-serial divider for the tick count, then S_DUTY and the result
// register; a new word is taken only once the last one has reached the result
// register, so item_in.ready is high only between words
// result_out has its own output register, so the next word is taken while a
// result waits; a stalled receiver holds the result and the word behind it waits
// reset: period counter and pin levels cleared, every turn-on tick set to 255
// (pin never turns on), registers back to 100 ticks and 200 counts, no result
module multi_channel_tick_pwm_core #(
  parameter int NUM_PINS = mctp_pkg::NUM_PINS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  mctp_in_if.sink    item_in,
  mctp_out_if.source result_out,
  mctp_cfg_if.sink   cfg
);

  mctp_pkg::ctrl_cmd_t  cmd;
  mctp_pkg::dp_status_t status;

  mctp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mctp_datapath #(
    .NUM_PINS (NUM_PINS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .result_out (result_out),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

// ===== hdl/mctp_checker.sv =====
module mctp_checker #(
  parameter int NUM_PINS = mctp_pkg::NUM_PINS_DEFAULT
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_action,
  input logic                out_valid,
  input logic                out_ready,
  input logic [NUM_PINS-1:0] pin_levels,
  input logic                period_end
);

  // a closing tick leaves every pin low
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && period_end |-> pin_levels == '0)
    else $error("period end with pins high");

  // one word at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  // a tick with a free output slot reaches out_valid via S_TICK
  a_tick_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_action == mctp_pkg::ACT_TICK) && !out_valid
      |=> ##1 out_valid)
    else $error("tick result late");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pin_levels) && $stable(period_end))
    else $error("stalled result changed");

endmodule

bind multi_channel_tick_pwm_core mctp_checker #(
  .NUM_PINS (NUM_PINS)
) u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (item_in.valid),
  .in_ready   (item_in.ready),
  .in_action  (item_in.action),
  .out_valid  (result_out.valid),
  .out_ready  (result_out.ready),
  .pin_levels (result_out.pin_levels),
  .period_end (result_out.period_end)
);
